// File: rtl/core/bte_pkg.sv
`default_nettype none

package bte_pkg;

  // Code that marks a missing time source or time format
  localparam logic [3:0] NONE_CODE = 4'hF;

  // Cycles from an accepted request to its result strobe
  localparam int unsigned LATENCY = 9;

  // Reciprocal of 400 scaled by 2^24, rounded down
  localparam logic [15:0] RECIP_400   = 16'd41943;
  localparam int unsigned RECIP_SHIFT = 24;

  // Days in a 400-year Gregorian cycle
  localparam logic [17:0] DAYS_PER_ERA = 18'd146097;

  // Days from 0000-03-01 to 1970-01-01 plus one shifted era plus one (day is 1-based)
  localparam logic [24:0] EPOCH_BIAS = 25'd865566;

  localparam logic [29:0] NS_PER_SEC = 30'd1000000000;
  localparam logic [19:0] NS_PER_MS  = 20'd1000000;
  localparam logic [16:0] SEC_PER_DAY = 17'd86400;

  // Split point of the seconds count for the nanosecond products
  localparam int unsigned SECS_W  = 42;
  localparam int unsigned SPLIT_W = 21;

  // Decoded request after the digit stages
  typedef struct packed {
    logic        valid;
    logic        invalid;
    logic        dmode;     // 1: year/month/day
    logic [14:0] ya;        // shifted year, 400 above the March-based year
    logic [8:0]  mdoy;      // days from March 1 to the month start
    logic [10:0] day_val;   // date mode: day of month, else day count from Jan 1
    logic [19:0] tod;       // seconds within the day
    logic [10:0] ms;        // milliseconds
  } bte_dec_t;

  // Request after the day count stages
  typedef struct packed {
    logic               valid;
    logic               invalid;
    logic               dmode;
    logic signed [24:0] days;
    logic [19:0]        tod;
    logic [10:0]        ms;
  } bte_days_t;

  // Days from March 1 to the first day of month m (1..12), March-based year
  function automatic logic [8:0] month_offset(input logic [3:0] m);
    logic [8:0] off;
    unique case (m)
      4'd3:    off = 9'd0;
      4'd4:    off = 9'd31;
      4'd5:    off = 9'd61;
      4'd6:    off = 9'd92;
      4'd7:    off = 9'd122;
      4'd8:    off = 9'd153;
      4'd9:    off = 9'd184;
      4'd10:   off = 9'd214;
      4'd11:   off = 9'd245;
      4'd12:   off = 9'd275;
      4'd1:    off = 9'd306;
      4'd2:    off = 9'd337;
      default: off = 9'd0;
    endcase
    return off;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/bte_decode.sv
`default_nettype none

module bte_decode (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire logic [3:0]        time_source_i,
  input  wire logic [3:0]        time_format_i,
  input  wire logic              date_format_i,
  input  wire logic [15:0]       year_bcd_i,
  input  wire logic [7:0]        month_bcd_i,
  input  wire logic [11:0]       day_bcd_i,
  input  wire logic [7:0]        hour_bcd_i,
  input  wire logic [7:0]        minute_bcd_i,
  input  wire logic [7:0]        second_bcd_i,
  input  wire logic [7:0]        fraction_bcd_i,
  output bte_pkg::bte_dec_t      dec_o
);
  import bte_pkg::*;

  // Stage 1 registers: weighted digits
  logic        s1_valid_q, s1_valid_d;
  logic        s1_invalid_q, s1_invalid_d;
  logic        s1_dmode_q, s1_dmode_d;
  logic [14:0] s1_year_q, s1_year_d;
  logic [7:0]  s1_mon_q, s1_mon_d;
  logic [10:0] s1_day_q, s1_day_d;
  logic [7:0]  s1_hour_q, s1_hour_d;
  logic [7:0]  s1_min_q, s1_min_d;
  logic [7:0]  s1_sec_q, s1_sec_d;
  logic [10:0] s1_ms_q, s1_ms_d;

  // Stage 2
  bte_dec_t    s2_q, s2_d;

  logic [7:0]  mon_t;
  logic [15:0] mon_prod;
  logic [4:0]  mon_carry;
  logic [7:0]  mon_norm;
  logic [3:0]  mon_m;
  logic        mon_early;

  // Weight each nibble by its decimal place, no digit check
  always_comb begin
    s1_valid_d   = accept_i;
    s1_invalid_d = (time_source_i == NONE_CODE) || (time_format_i == NONE_CODE);
    s1_dmode_d   = date_format_i;
    s1_year_d    = 15'(15'(year_bcd_i[15:12]) * 15'd1000)
                 + 15'(15'(year_bcd_i[11:8]) * 15'd100)
                 + 15'(15'(year_bcd_i[7:4]) * 15'd10)
                 + 15'(year_bcd_i[3:0]);
    s1_mon_d     = 8'(8'(month_bcd_i[7:4]) * 8'd10) + 8'(month_bcd_i[3:0]);
    if (date_format_i) begin
      s1_day_d = 11'(11'(day_bcd_i[7:4]) * 11'd10) + 11'(day_bcd_i[3:0]);
    end else begin
      s1_day_d = 11'(11'(day_bcd_i[11:8]) * 11'd100)
               + 11'(11'(day_bcd_i[7:4]) * 11'd10)
               + 11'(day_bcd_i[3:0]);
    end
    s1_hour_d = 8'(8'(hour_bcd_i[7:4]) * 8'd10) + 8'(hour_bcd_i[3:0]);
    s1_min_d  = 8'(8'(minute_bcd_i[7:4]) * 8'd10) + 8'(minute_bcd_i[3:0]);
    s1_sec_d  = 8'(8'(second_bcd_i[7:4]) * 8'd10) + 8'(second_bcd_i[3:0]);
    s1_ms_d   = 11'(11'(fraction_bcd_i[7:4]) * 11'd100)
              + 11'(11'(fraction_bcd_i[3:0]) * 11'd10);
  end

  // Fold month overflow into years, shift to a March-based year, sum time of day
  always_comb begin
    // carry count plus one: floor((month + 11) / 12) by reciprocal
    mon_t     = s1_mon_q + 8'd11;
    mon_prod  = 16'(mon_t) * 16'd171;
    mon_carry = mon_prod[15:11];
    mon_norm  = s1_mon_q + 8'd12 - 8'(8'(mon_carry) * 8'd12);
    mon_m     = mon_norm[3:0];
    mon_early = (mon_m <= 4'd2);

    s2_d.valid   = s1_valid_q;
    s2_d.invalid = s1_invalid_q;
    s2_d.dmode   = s1_dmode_q;
    s2_d.ya      = s1_year_q + 15'(mon_carry) + 15'd399 - 15'(mon_early);
    s2_d.mdoy    = month_offset(mon_m);
    if (s1_dmode_q) begin
      s2_d.day_val = s1_day_q;
    end else if (s1_day_q == 11'd0) begin
      s2_d.day_val = 11'd0;
    end else begin
      s2_d.day_val = s1_day_q - 11'd1;
    end
    s2_d.tod = 20'(20'(s1_hour_q) * 20'd3600) + 20'(20'(s1_min_q) * 20'd60)
             + 20'(s1_sec_q);
    s2_d.ms  = s1_ms_q;
  end

  // Valid bits and stage 2
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_q       <= '0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_q       <= s2_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    s1_invalid_q <= s1_invalid_d;
    s1_dmode_q   <= s1_dmode_d;
    s1_year_q    <= s1_year_d;
    s1_mon_q     <= s1_mon_d;
    s1_day_q     <= s1_day_d;
    s1_hour_q    <= s1_hour_d;
    s1_min_q     <= s1_min_d;
    s1_sec_q     <= s1_sec_d;
    s1_ms_q      <= s1_ms_d;
  end

  assign dec_o = s2_q;

endmodule

`default_nettype wire

// File: rtl/core/bte_days.sv
`default_nettype none

module bte_days (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire bte_pkg::bte_dec_t dec_i,
  output bte_pkg::bte_days_t days_o
);
  import bte_pkg::*;

  // Stage 3: era estimate
  bte_dec_t    s3_q;
  logic [5:0]  s3_qest_q, s3_qest_d;
  logic [30:0] est_prod;

  // Stage 4: corrected era and year of era
  bte_dec_t    s4_q;
  logic [5:0]  s4_era_q, s4_era_d;
  logic [8:0]  s4_yoe_q, s4_yoe_d;
  logic [14:0] rem_raw;

  // Stage 5: day of era and era base
  bte_dec_t    s5_q;
  logic [17:0] s5_doe_q, s5_doe_d;
  logic [22:0] s5_base_q, s5_base_d;
  logic [1:0]  cent;

  // Stage 6: day count
  bte_days_t   s6_q, s6_d;
  logic signed [24:0] date_days;

  // Estimate ya / 400 with a reciprocal, low by at most one
  always_comb begin
    est_prod  = 31'(dec_i.ya) * 31'(RECIP_400);
    s3_qest_d = est_prod[RECIP_SHIFT +: 6];
  end

  // Correct the estimate with one compare and subtract
  always_comb begin
    rem_raw = s3_q.ya - 15'(15'(s3_qest_q) * 15'd400);
    if (rem_raw >= 15'd400) begin
      s4_era_d = s3_qest_q + 6'd1;
      s4_yoe_d = 9'(rem_raw - 15'd400);
    end else begin
      s4_era_d = s3_qest_q;
      s4_yoe_d = 9'(rem_raw);
    end
  end

  // Day of era: yoe*365 + yoe/4 - yoe/100 + month offset
  always_comb begin
    priority if (s4_yoe_q >= 9'd300) begin
      cent = 2'd3;
    end else if (s4_yoe_q >= 9'd200) begin
      cent = 2'd2;
    end else if (s4_yoe_q >= 9'd100) begin
      cent = 2'd1;
    end else begin
      cent = 2'd0;
    end
    s5_doe_d  = 18'(18'(s4_yoe_q) * 18'd365) + 18'(s4_yoe_q[8:2]) - 18'(cent)
              + 18'(s4_q.mdoy);
    s5_base_d = 23'(23'(s4_era_q) * 23'(DAYS_PER_ERA));
  end

  // Days from the epoch in date mode, else the day count from Jan 1
  always_comb begin
    date_days = $signed(25'(s5_base_q)) + $signed(25'(s5_doe_q))
              + $signed(25'(s5_q.day_val)) - $signed(EPOCH_BIAS);
    s6_d.valid   = s5_q.valid;
    s6_d.invalid = s5_q.invalid;
    s6_d.dmode   = s5_q.dmode;
    s6_d.days    = s5_q.dmode ? date_days : $signed(25'(s5_q.day_val));
    s6_d.tod     = s5_q.tod;
    s6_d.ms      = s5_q.ms;
  end

  // Valid bits with the request they carry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_q <= '0;
      s4_q <= '0;
      s5_q <= '0;
      s6_q <= '0;
    end else begin
      s3_q <= dec_i;
      s4_q <= s3_q;
      s5_q <= s4_q;
      s6_q <= s6_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    s3_qest_q    <= s3_qest_d;
    s4_era_q     <= s4_era_d;
    s4_yoe_q     <= s4_yoe_d;
    s5_doe_q     <= s5_doe_d;
    s5_base_q    <= s5_base_d;
  end

  assign days_o = s6_q;

endmodule

`default_nettype wire

// File: rtl/core/bte_scale.sv
`default_nettype none

module bte_scale (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire bte_pkg::bte_days_t days_i,
  output logic                valid_o,
  output logic                status_o,
  output logic [63:0]         epoch_nanoseconds_o,
  output logic                day_of_year_mode_o
);
  import bte_pkg::*;

  // Stage 7: seconds count
  logic                      s7_valid_q;
  logic                      s7_invalid_q;
  logic                      s7_dmode_q;
  logic signed [SECS_W-1:0]  s7_secs_q, s7_secs_d;
  logic [10:0]               s7_ms_q;

  // Stage 8: partial products
  logic                      s8_valid_q;
  logic                      s8_invalid_q;
  logic                      s8_dmode_q;
  logic [50:0]               s8_plo_q, s8_plo_d;
  logic signed [51:0]        s8_phi_q, s8_phi_d;
  logic [30:0]               s8_msns_q, s8_msns_d;

  // Stage 9: result
  logic                      s9_valid_q;
  logic                      s9_status_q, s9_status_d;
  logic                      s9_dmode_q, s9_dmode_d;
  logic [63:0]               s9_ns_q, s9_ns_d;
  logic [63:0]               phi_ext;

  // Scale days to seconds and add the time of day
  always_comb begin
    s7_secs_d = SECS_W'($signed(days_i.days)) * $signed(SECS_W'(SEC_PER_DAY))
              + $signed(SECS_W'(days_i.tod));
  end

  // Split the seconds count to keep each product narrow
  always_comb begin
    s8_plo_d  = 51'(s7_secs_q[SPLIT_W-1:0]) * 51'(NS_PER_SEC);
    s8_phi_d  = 52'($signed(s7_secs_q[SECS_W-1:SPLIT_W])) * $signed(52'(NS_PER_SEC));
    s8_msns_d = 31'(s7_ms_q) * 31'(NS_PER_MS);
  end

  // Recombine modulo 2^64; drop to zero on an invalid request
  always_comb begin
    phi_ext     = 64'($signed(s8_phi_q));
    s9_status_d = s8_invalid_q;
    s9_dmode_d  = !s8_invalid_q && !s8_dmode_q;
    if (s8_invalid_q) begin
      s9_ns_d = 64'd0;
    end else begin
      s9_ns_d = (phi_ext << SPLIT_W) + 64'(s8_plo_q) + 64'(s8_msns_q);
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s7_valid_q <= 1'b0;
      s8_valid_q <= 1'b0;
      s9_valid_q <= 1'b0;
    end else begin
      s7_valid_q <= days_i.valid;
      s8_valid_q <= s7_valid_q;
      s9_valid_q <= s8_valid_q;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    s7_invalid_q <= days_i.invalid;
    s7_dmode_q   <= days_i.dmode;
    s7_secs_q    <= s7_secs_d;
    s7_ms_q      <= days_i.ms;
    s8_invalid_q <= s7_invalid_q;
    s8_dmode_q   <= s7_dmode_q;
    s8_plo_q     <= s8_plo_d;
    s8_phi_q     <= s8_phi_d;
    s8_msns_q    <= s8_msns_d;
    s9_status_q  <= s9_status_d;
    s9_dmode_q   <= s9_dmode_d;
    s9_ns_q      <= s9_ns_d;
  end

  assign valid_o             = s9_valid_q;
  assign status_o            = s9_status_q;
  assign epoch_nanoseconds_o = s9_ns_q;
  assign day_of_year_mode_o  = s9_dmode_q;

endmodule

`default_nettype wire

// File: rtl/core/bcd_time_to_epoch_ns.sv
// Each accepted request yields a one-cycle valid_o strobe.
// Throughput: one request per cycle while busy is low; nine fully pipelined
// stages, with the nanosecond scaling split into two half-width products.
// Reset: asynchronous, active low; clears all stage valid bits. busy is high
// during reset and in the first cycle after it, then stays low.
// The receiver cannot stall; results leave on the strobe cycle.
`default_nettype none

module bcd_time_to_epoch_ns (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [3:0]  time_source_i,
  input  wire logic [3:0]  time_format_i,
  input  wire logic        date_format_i,
  input  wire logic [15:0] year_bcd_i,
  input  wire logic [7:0]  month_bcd_i,
  input  wire logic [11:0] day_bcd_i,
  input  wire logic [7:0]  hour_bcd_i,
  input  wire logic [7:0]  minute_bcd_i,
  input  wire logic [7:0]  second_bcd_i,
  input  wire logic [7:0]  fraction_bcd_i,
  output logic             valid_o,
  output logic             status_o,
  output logic [63:0]      epoch_nanoseconds_o,
  output logic             day_of_year_mode_o
);
  import bte_pkg::*;

  logic      busy_q, busy_d;
  logic      accept;
  bte_dec_t  dec;
  bte_days_t days;

  // Hold requests off until reset has settled
  assign busy_d = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
    end else begin
      busy_q <= busy_d;
    end
  end

  assign busy   = busy_q;
  assign accept = start && !busy_q;

  bte_decode u_decode (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .time_source_i  (time_source_i),
    .time_format_i  (time_format_i),
    .date_format_i  (date_format_i),
    .year_bcd_i     (year_bcd_i),
    .month_bcd_i    (month_bcd_i),
    .day_bcd_i      (day_bcd_i),
    .hour_bcd_i     (hour_bcd_i),
    .minute_bcd_i   (minute_bcd_i),
    .second_bcd_i   (second_bcd_i),
    .fraction_bcd_i (fraction_bcd_i),
    .dec_o          (dec)
  );

  bte_days u_days (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .dec_i  (dec),
    .days_o (days)
  );

  bte_scale u_scale (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .days_i              (days),
    .valid_o             (valid_o),
    .status_o            (status_o),
    .epoch_nanoseconds_o (epoch_nanoseconds_o),
    .day_of_year_mode_o  (day_of_year_mode_o)
  );

endmodule

`default_nettype wire

// File: rtl/core/bte_checker.sv
`default_nettype none

module bte_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start,
  input wire logic        busy,
  input wire logic [3:0]  time_source_i,
  input wire logic [3:0]  time_format_i,
  input wire logic        date_format_i,
  input wire logic        valid_o,
  input wire logic        status_o,
  input wire logic [63:0] epoch_nanoseconds_o,
  input wire logic        day_of_year_mode_o
);
  import bte_pkg::*;

  logic req;
  logic req_bad;

  assign req     = start && !busy;
  assign req_bad = (time_source_i == NONE_CODE) || (time_format_i == NONE_CODE);

  // Every request yields a strobe after the fixed latency
  a_req_to_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req |-> ##LATENCY valid_o)
    else $error("request without result");

  // No strobe without a request the fixed latency earlier
  a_result_from_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(req, LATENCY))
    else $error("result without request");

  // A missing source or format reports invalid with zero time
  a_invalid_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req && req_bad) |-> ##LATENCY
      (status_o && (epoch_nanoseconds_o == 64'd0) && !day_of_year_mode_o))
    else $error("invalid request not reported");

  // A valid day-of-year request reports its mode
  a_doy_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req && !req_bad && !date_format_i) |-> ##LATENCY
      (!status_o && day_of_year_mode_o))
    else $error("day-of-year mode lost");

endmodule

bind bcd_time_to_epoch_ns bte_checker u_bte_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .start               (start),
  .busy                (busy),
  .time_source_i       (time_source_i),
  .time_format_i       (time_format_i),
  .date_format_i       (date_format_i),
  .valid_o             (valid_o),
  .status_o            (status_o),
  .epoch_nanoseconds_o (epoch_nanoseconds_o),
  .day_of_year_mode_o  (day_of_year_mode_o)
);

`default_nettype wire
